// ----- sv/hbphi_pkg.sv -----
// ----------------------------------------------------------------------------
// hbphi_pkg
// Shared constants and codes for the heartbeat phi failure detector.
// ----------------------------------------------------------------------------
package hbphi_pkg;

  localparam int WINDOW_DEPTH = 16;
  localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
  localparam int COUNT_W      = $clog2(WINDOW_DEPTH + 1);

  localparam int OPCODE_W     = 2;
  localparam int STAMP_W      = 64;
  localparam int IVAL_W       = 32;
  localparam int TOTAL_W      = IVAL_W + SLOT_W;
  localparam int THR_W        = 16;
  localparam int SAMPLES_W    = 5;

  localparam logic [THR_W-1:0] THR_RESET = 16'd2048;

  localparam int                  LOG10E_W   = 15;
  localparam logic [LOG10E_W-1:0] LOG10E_Q16 = 15'd28462;
  localparam int                  MIN_SAMPLES = 3;

  localparam int K_W    = COUNT_W + LOG10E_W;
  localparam int LHS_W  = IVAL_W + K_W;
  localparam int RLO_W  = THR_W + IVAL_W;
  localparam int RHI_W  = THR_W + SLOT_W;
  localparam int RSUM_W = THR_W + TOTAL_W;
  localparam int RHS_W  = RSUM_W + 8;
  localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;

  typedef enum logic [OPCODE_W-1:0] {
    OP_BEAT       = 2'd0,
    OP_CLEAR_BEAT = 2'd1,
    OP_CLEAR      = 2'd2,
    OP_NONE       = 2'd3
  } opcode_t;

endpackage

// ----- sv/hbphi_ram.sv -----
// ----------------------------------------------------------------------------
// hbphi_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module hbphi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/heartbeat_phi_failure_detector_top.sv -----
// ----------------------------------------------------------------------------
// heartbeat_phi_failure_detector_top
// Phi accrual failure detector over heartbeat timestamps.
// ----------------------------------------------------------------------------
// Each accepted beat passes through the states in order: ST_LOAD applies a
// clear, forms the interval and issues the ring read, ST_READ does the
// read-modify-write of the interval ring and running sum, ST_MUL1 and ST_MUL2
// do the split multiplies, ST_CMP the final add and compare, and ST_DONE
// loads the output register once it is free. A beat that records no interval
// goes from ST_LOAD straight to ST_DONE. One beat is in work at a time, and
// the next is accepted while the previous result waits at the output register.
module heartbeat_phi_failure_detector_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [hbphi_pkg::THR_W-1:0]     cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [hbphi_pkg::OPCODE_W-1:0]  opcode,
  input  logic [hbphi_pkg::STAMP_W-1:0]   stamp_usec,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            leader_failed,
  output logic                            interval_recorded,
  output logic [hbphi_pkg::SAMPLES_W-1:0] samples_held
);

  import hbphi_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_LOAD = 7'b0000010,
    ST_READ = 7'b0000100,
    ST_MUL1 = 7'b0001000,
    ST_MUL2 = 7'b0010000,
    ST_CMP  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  state_t               state;
  opcode_t              op_q;
  logic [STAMP_W-1:0]   stamp_q;
  logic [STAMP_W-1:0]   previous_stamp;
  logic [SLOT_W-1:0]    write_slot;
  logic [COUNT_W-1:0]   sample_count;
  logic [TOTAL_W-1:0]   interval_total;
  logic [THR_W-1:0]     phi_threshold_q8;
  logic [IVAL_W-1:0]    ival;
  logic [K_W-1:0]       lhs_k;
  logic [RLO_W-1:0]     rhs_lo;
  logic [LHS_W-1:0]     lhs;
  logic [RHI_W-1:0]     rhs_hi;
  logic                 res_failed;
  logic                 res_stored;
  logic [SAMPLES_W-1:0] res_count;

  logic                 clr;
  logic                 hb;
  logic [STAMP_W-1:0]   prev_eff;
  logic [STAMP_W-1:0]   diff;
  logic [IVAL_W-1:0]    ival_next;
  logic                 go_on;
  logic                 full;
  logic [TOTAL_W-1:0]   total_next;
  logic [COUNT_W-1:0]   count_next;
  logic [SLOT_W-1:0]    slot_next;
  logic [RSUM_W-1:0]    rhs_sum;
  logic [RHS_W-1:0]     rhs_full;
  logic                 failed_next;
  logic                 ram_we;
  logic [SLOT_W-1:0]    ram_raddr;
  logic [IVAL_W-1:0]    ram_rdata;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    clr       = op_q inside {OP_CLEAR_BEAT, OP_CLEAR};
    hb        = op_q inside {OP_BEAT, OP_CLEAR_BEAT};
    prev_eff  = clr ? '0 : previous_stamp;
    diff      = stamp_q - prev_eff;
    ival_next = (|diff[STAMP_W-1:IVAL_W]) ? '1 : diff[IVAL_W-1:0];
    go_on     = hb && (prev_eff != '0);
    ram_raddr = clr ? '0 : write_slot;
  end

  always_comb begin
    full       = (sample_count == COUNT_W'(WINDOW_DEPTH));
    total_next = interval_total - (full ? TOTAL_W'(ram_rdata) : '0) + TOTAL_W'(ival);
    count_next = full ? sample_count : sample_count + 1'b1;
    slot_next  = (write_slot == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : write_slot + 1'b1;
    ram_we     = (state == ST_READ);
  end

  always_comb begin
    rhs_sum     = {rhs_hi, {IVAL_W{1'b0}}} + RSUM_W'(rhs_lo);
    rhs_full    = {rhs_sum, 8'b0};
    failed_next = (sample_count >= COUNT_W'(MIN_SAMPLES)) && (ival != '0)
                  && (interval_total != '0) && (CMP_W'(lhs) > CMP_W'(rhs_full));
  end

  hbphi_ram #(
    .WIDTH (IVAL_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_slot),
    .wdata (ival),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phi_threshold_q8 <= THR_RESET;
    end else if (cfg_wen) begin
      phi_threshold_q8 <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      previous_stamp <= '0;
      write_slot     <= '0;
      sample_count   <= '0;
      interval_total <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (state == ST_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op_q    <= opcode_t'(opcode);
            stamp_q <= stamp_usec;
            state   <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (clr) begin
            write_slot     <= '0;
            sample_count   <= '0;
            interval_total <= '0;
          end
          if (hb) begin
            previous_stamp <= stamp_q;
          end else if (clr) begin
            previous_stamp <= '0;
          end
          ival <= ival_next;
          if (go_on) begin
            state <= ST_READ;
          end else begin
            res_failed <= 1'b0;
            res_stored <= 1'b0;
            res_count  <= clr ? '0 : SAMPLES_W'(sample_count);
            state      <= ST_DONE;
          end
        end
        ST_READ: begin
          write_slot     <= slot_next;
          sample_count   <= count_next;
          interval_total <= total_next;
          res_stored     <= 1'b1;
          res_count      <= SAMPLES_W'(count_next);
          state          <= ST_MUL1;
        end
        ST_MUL1: begin
          lhs_k  <= K_W'(sample_count) * K_W'(LOG10E_Q16);
          rhs_lo <= RLO_W'(phi_threshold_q8) * RLO_W'(interval_total[IVAL_W-1:0]);
          state  <= ST_MUL2;
        end
        ST_MUL2: begin
          lhs    <= LHS_W'(ival) * LHS_W'(lhs_k);
          rhs_hi <= RHI_W'(phi_threshold_q8) * RHI_W'(interval_total[TOTAL_W-1:IVAL_W]);
          state  <= ST_CMP;
        end
        ST_CMP: begin
          res_failed <= failed_next;
          state      <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            leader_failed     <= res_failed;
            interval_recorded <= res_stored;
            samples_held      <= res_count;
            state             <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_fail_needs_interval: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!leader_failed || interval_recorded))
    else $error("Failure flagged on a beat that recorded no interval.");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    sample_count <= COUNT_W'(WINDOW_DEPTH))
    else $error("Sample count exceeds the window depth.");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("A second beat was accepted while one is in work.");

  a_ring_write_advances: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> (res_stored && (sample_count != '0)))
    else $error("Ring write did not record a sample.");

endmodule

// ----- tb/tb_heartbeat_phi_failure_detector_top.sv -----
// ----------------------------------------------------------------------------
// tb_heartbeat_phi_failure_detector_top
// Self-checking testbench for the heartbeat phi failure detector. Directed
// beats cover every opcode, the start mark, zero, backwards and saturated
// intervals and the threshold extremes. Random phases then send jittered
// heartbeat streams with spikes, clears and noise under several thresholds.
// Expected results come from a behavioral model of the window and the
// fixed-point phi test and are compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_heartbeat_phi_failure_detector_top;

  import hbphi_pkg::*;

  localparam int          DRAIN_CYCLES  = 12;
  localparam logic [31:0] PHI_LOG10E    = 32'd28462;
  localparam int          PHI_MIN_COUNT = 3;

  typedef struct packed {
    logic                 failed;
    logic                 recorded;
    logic [SAMPLES_W-1:0] held;
  } beat_result_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_wen;
  logic [THR_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic [OPCODE_W-1:0]  opcode;
  logic [STAMP_W-1:0]   stamp_usec;
  logic                 out_valid;
  logic                 out_ready;
  logic                 leader_failed;
  logic                 interval_recorded;
  logic [SAMPLES_W-1:0] samples_held;

  beat_result_t expected_results[$];
  int           mismatch_count;
  bit           gaps_on;
  bit           stalls_on;

  // Model of the detector state.
  logic [THR_W-1:0]  phi_thr;
  logic [63:0]       last_stamp;
  logic [31:0]       ival_ring[WINDOW_DEPTH];
  logic [SLOT_W-1:0] next_slot;
  int                held_count;
  logic [63:0]       ival_sum;

  // Heartbeat stream generator state.
  logic [63:0] now_stamp;
  logic [31:0] period;

  heartbeat_phi_failure_detector_top i_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_wen           (cfg_wen),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .opcode            (opcode),
    .stamp_usec        (stamp_usec),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .leader_failed     (leader_failed),
    .interval_recorded (interval_recorded),
    .samples_held      (samples_held)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void clear_window();
    last_stamp = '0;
    next_slot  = '0;
    held_count = 0;
    ival_sum   = '0;
  endfunction

  function automatic beat_result_t predict_beat(opcode_t op, logic [63:0] stamp);
    beat_result_t res;
    logic [63:0]  diff;
    logic [31:0]  ival;
    logic [127:0] lhs;
    logic [127:0] rhs;
    res = '0;
    if (op == OP_CLEAR_BEAT || op == OP_CLEAR) begin
      clear_window();
    end
    if (op == OP_BEAT || op == OP_CLEAR_BEAT) begin
      if (last_stamp == '0) begin
        last_stamp = stamp;
      end else begin
        diff       = stamp - last_stamp;
        last_stamp = stamp;
        ival       = (diff > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : diff[31:0];
        if (held_count >= WINDOW_DEPTH) begin
          ival_sum = ival_sum - 64'(ival_ring[next_slot]);
        end else begin
          held_count++;
        end
        ival_ring[next_slot] = ival;
        ival_sum             = ival_sum + 64'(ival);
        next_slot            = next_slot + 1'b1;
        res.recorded         = 1'b1;
        if (held_count >= PHI_MIN_COUNT && ival != '0 && ival_sum != '0) begin
          lhs = 128'(ival) * 128'(held_count) * 128'(PHI_LOG10E);
          rhs = 128'(phi_thr) * 128'(ival_sum) * 128'd256;
          res.failed = (lhs > rhs);
        end
      end
    end
    res.held = SAMPLES_W'(held_count);
    return res;
  endfunction

  task automatic report_mismatch(string field, int unsigned want, int unsigned got);
    mismatch_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    beat_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual %0b %0b %0d", $time,
                 leader_failed, interval_recorded, samples_held);
      end else begin
        want = expected_results.pop_front();
        if (leader_failed !== want.failed) begin
          report_mismatch("leader_failed", 32'(want.failed), 32'(leader_failed));
        end
        if (interval_recorded !== want.recorded) begin
          report_mismatch("interval_recorded", 32'(want.recorded),
                          32'(interval_recorded));
        end
        if (samples_held !== want.held) begin
          report_mismatch("samples_held", 32'(want.held), 32'(samples_held));
        end
      end
    end
  end

  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stalls_on && $urandom_range(0, 9) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_ready = 1'b1;
      end
    end
  end

  task automatic send_beat(opcode_t op, logic [63:0] stamp);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid   = 1'b1;
    opcode     = op;
    stamp_usec = stamp;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_beat(op, stamp));
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] value);
    wait_all_results();
    @(negedge clk);
    cfg_wen   = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_wen   = 1'b0;
    phi_thr   = value;
  endtask

  task automatic pick_period();
    case ($urandom_range(0, 3))
      0:       period = $urandom_range(1, 20);
      1:       period = $urandom_range(100, 5000);
      2:       period = $urandom_range(10000, 1000000);
      default: period = $urandom;
    endcase
    if (period == '0) begin
      period = 32'd1;
    end
  endtask

  task automatic run_stream(int count);
    int          pick;
    opcode_t     op;
    logic [63:0] step;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      op   = OP_BEAT;
      step = 64'(period) - 64'(period / 8) + 64'($urandom_range(0, period / 4));
      if (pick < 70) begin
        now_stamp = now_stamp + step;
      end else if (pick < 78) begin
        now_stamp = now_stamp + 64'(period) * 64'($urandom_range(3, 40));
      end else if (pick < 81) begin
        now_stamp = now_stamp;
      end else if (pick < 83) begin
        now_stamp = now_stamp - 64'($urandom_range(1, period));
      end else if (pick < 85) begin
        now_stamp = now_stamp + {32'($urandom_range(1, 32'hFFFF)), 32'($urandom)};
      end else if (pick < 88) begin
        op        = OP_CLEAR_BEAT;
        now_stamp = now_stamp + step;
      end else if (pick < 90) begin
        op = OP_CLEAR;
      end else if (pick < 92) begin
        op = OP_NONE;
      end else if (pick < 94) begin
        send_beat(OP_BEAT, '0);
        continue;
      end else if (pick < 97) begin
        pick_period();
        now_stamp = now_stamp + 64'(period);
      end else begin
        now_stamp = {$urandom, $urandom};
      end
      send_beat(op, (op == OP_NONE) ? {$urandom, $urandom} : now_stamp);
    end
  endtask

  task automatic new_stream();
    now_stamp = {$urandom, $urandom};
    pick_period();
  endtask

  task automatic test_start_and_opcodes();
    send_beat(OP_NONE, 64'd123);
    send_beat(OP_BEAT, 64'd1000);
    send_beat(OP_BEAT, 64'd2000);
    send_beat(OP_BEAT, 64'd3000);
    send_beat(OP_BEAT, 64'd4000);
    send_beat(OP_NONE, 64'd77);
    send_beat(OP_CLEAR, 64'd5);
    send_beat(OP_CLEAR_BEAT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_beat(OP_BEAT, 64'd0);
    send_beat(OP_BEAT, 64'd50);
    send_beat(OP_BEAT, 64'd0);
  endtask

  task automatic test_interval_edges();
    write_threshold(16'h0000);
    send_beat(OP_CLEAR_BEAT, 64'd100);
    send_beat(OP_BEAT, 64'd100);
    send_beat(OP_BEAT, 64'd200);
    send_beat(OP_BEAT, 64'd300);
    send_beat(OP_BEAT, 64'd300);
    send_beat(OP_BEAT, 64'd300 + (64'd1 << 40));
    send_beat(OP_BEAT, 64'd299);
    write_threshold(16'hFFFF);
    send_beat(OP_BEAT, 64'd299 + (64'd1 << 33));
    send_beat(OP_BEAT, 64'd300 + (64'd1 << 33));
  endtask

  task automatic test_threshold_sweep();
    logic [THR_W-1:0] thr;
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0:       thr = 16'd256;
        1:       thr = 16'hFFFF;
        2:       thr = 16'd0;
        3:       thr = 16'd128;
        4:       thr = THR_RESET;
        5:       thr = 16'd1;
        6:       thr = 16'($urandom);
        default: thr = 16'($urandom_range(0, 1024));
      endcase
      write_threshold(thr);
      new_stream();
      run_stream(150);
    end
  endtask

  task automatic test_noise();
    logic [63:0] stamp;
    write_threshold(16'($urandom_range(0, 512)));
    for (int i = 0; i < 150; i++) begin
      stamp = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom} : 64'($urandom_range(0, 40));
      send_beat(opcode_t'($urandom_range(0, 3)), stamp);
    end
  endtask

  task automatic test_steady_stream();
    write_threshold(16'($urandom_range(64, 400)));
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    new_stream();
    run_stream(200);
  endtask

  initial begin
    rst            = 1'b1;
    cfg_wen        = 1'b0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    opcode         = OP_BEAT;
    stamp_usec     = '0;
    gaps_on        = 1'b1;
    stalls_on      = 1'b1;
    mismatch_count = 0;
    phi_thr        = THR_RESET;
    clear_window();
    now_stamp      = '0;
    period         = 32'd1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_start_and_opcodes();
    test_interval_edges();
    test_threshold_sweep();
    test_noise();
    test_steady_stream();
    wait_all_results();

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/hbphi_pkg.sv
sv/hbphi_ram.sv
sv/heartbeat_phi_failure_detector_top.sv
tb/tb_heartbeat_phi_failure_detector_top.sv
